### rtl/masked_weighted_mean_abs_distance_defines.svh
// Assertion macros for the masked weighted mean absolute distance block.
// Used by the top level only; needs no package.
`ifndef MASKED_WEIGHTED_MEAN_ABS_DISTANCE_DEFINES_SVH
`define MASKED_WEIGHTED_MEAN_ABS_DISTANCE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define MWMAD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define MWMAD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mwmad_pkg.sv
// Shared types and constants of the masked weighted mean absolute distance block.
// No dependencies; the queue, front, back and top-level files import this package.
`default_nettype none

package mwmad_pkg;

    // Field widths
    localparam int SCORE_W  = 32;
    localparam int WEIGHT_W = 16;
    localparam int DIFF_W   = 32;
    localparam int PROD_W   = DIFF_W + WEIGHT_W;
    localparam int WSUM_W   = 64;
    localparam int WTSUM_W  = 27;
    localparam int COUNT_W  = 11;
    localparam int DIST_W   = 31;
    localparam int FRAC_W   = 16;

    // Reset value of the missing-value floor: -9999.0 in Q16.16
    localparam logic signed [SCORE_W-1:0] FLOOR_RESET = 32'shD8F1_0000;

    // Depth of the queue between accumulation and division
    localparam int QUEUE_DEPTH = 2;

    // One input request
    typedef struct packed {
        logic signed [SCORE_W-1:0] a_score;
        logic signed [SCORE_W-1:0] b_score;
        logic [WEIGHT_W-1:0]       weight;
        logic                      last;
    } in_item_t;

    // One result
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              no_data;
    } out_item_t;

    // Accumulator snapshot of one finished vector
    typedef struct packed {
        logic [WSUM_W-1:0]  weighted_sum;
        logic [WTSUM_W-1:0] weight_sum;
        logic [COUNT_W-1:0] element_count;
    } snap_t;

endpackage

`default_nettype wire

### rtl/mwmad_queue.sv
// Short FIFO of accumulator snapshots between the front and the divider.
// Depends on mwmad_pkg for the snapshot type.
`default_nettype none

module mwmad_queue #(
    parameter int DEPTH = mwmad_pkg::QUEUE_DEPTH
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push_valid,
    output logic                push_ready,
    input  mwmad_pkg::snap_t    push_data,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output mwmad_pkg::snap_t    pop_data
);
    import mwmad_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    snap_t              slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               do_push, do_pop;

    assign push_ready = (fill_reg != CNT_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store pushed snapshots
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/mwmad_front.sv
// Front part: accepts score requests, masks missing pairs, multiplies and accumulates.
// Pushes one accumulator snapshot per vector; depends on mwmad_pkg.
`default_nettype none

module mwmad_front (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire signed [mwmad_pkg::SCORE_W-1:0]    missing_floor,
    input  wire                                    s_valid,
    output logic                                   s_ready,
    input  mwmad_pkg::in_item_t                    s_item,
    output logic                                   push_valid,
    input  wire                                    push_ready,
    output mwmad_pkg::snap_t                       push_data
);
    import mwmad_pkg::*;

    logic                       adv;

    // Stage 1: captured request
    logic                       p1_valid_reg;
    in_item_t                   p1_item_reg;

    // Stage 2: masked absolute difference
    logic                       p2_valid_reg;
    logic                       p2_last_reg;
    logic [DIFF_W-1:0]          p2_diff_reg, p2_diff_next;
    logic [WEIGHT_W-1:0]        p2_weight_reg, p2_weight_next;
    logic                       used;
    logic signed [SCORE_W:0]    diff_full;
    logic signed [SCORE_W:0]    diff_abs;

    // Stage 3: weighted product
    logic                       p3_valid_reg;
    logic                       p3_last_reg;
    logic [PROD_W-1:0]          p3_prod_reg, p3_prod_next;
    logic [WEIGHT_W-1:0]        p3_weight_reg;

    // Accumulators
    logic [WSUM_W-1:0]          wsum_reg, wsum_next;
    logic [WTSUM_W-1:0]         wtsum_reg, wtsum_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic [WSUM_W:0]            wsum_add;
    logic [WTSUM_W:0]           wtsum_add;
    logic [WSUM_W-1:0]          wsum_sat;
    logic [WTSUM_W-1:0]         wtsum_sat;
    logic [COUNT_W-1:0]         count_sat;

    // Stall the whole pipe only while a finished vector waits for queue space
    assign adv        = !(p3_valid_reg && p3_last_reg && !push_ready);
    assign s_ready    = adv;
    assign push_valid = p3_valid_reg && p3_last_reg;

    // Mask missing pairs and take the absolute difference
    always_comb begin
        used      = ($signed(p1_item_reg.a_score) >= missing_floor) &&
                    ($signed(p1_item_reg.b_score) >= missing_floor);
        diff_full = $signed({p1_item_reg.a_score[SCORE_W-1], p1_item_reg.a_score}) -
                    $signed({p1_item_reg.b_score[SCORE_W-1], p1_item_reg.b_score});
        diff_abs  = diff_full[SCORE_W] ? -diff_full : diff_full;
        p2_diff_next   = diff_abs[DIFF_W-1:0];
        p2_weight_next = used ? p1_item_reg.weight : '0;
    end

    // Weight the difference
    assign p3_prod_next = p2_diff_reg * p2_weight_reg;

    // Saturating accumulation
    always_comb begin
        wsum_add  = {1'b0, wsum_reg} + {{(WSUM_W + 1 - PROD_W){1'b0}}, p3_prod_reg};
        wtsum_add = {1'b0, wtsum_reg} + {{(WTSUM_W + 1 - WEIGHT_W){1'b0}}, p3_weight_reg};
        wsum_sat  = wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];
        wtsum_sat = wtsum_add[WTSUM_W] ? '1 : wtsum_add[WTSUM_W-1:0];
        count_sat = (count_reg == '1) ? count_reg : count_reg + 1'b1;

        push_data.weighted_sum  = wsum_sat;
        push_data.weight_sum    = wtsum_sat;
        push_data.element_count = count_sat;

        wsum_next  = wsum_reg;
        wtsum_next = wtsum_reg;
        count_next = count_reg;
        if (p3_valid_reg && adv) begin
            if (p3_last_reg) begin
                wsum_next  = '0;
                wtsum_next = '0;
                count_next = '0;
            end else begin
                wsum_next  = wsum_sat;
                wtsum_next = wtsum_sat;
                count_next = count_sat;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            wsum_reg     <= '0;
            wtsum_reg    <= '0;
            count_reg    <= '0;
        end else begin
            if (adv) begin
                p1_valid_reg <= s_valid;
                p2_valid_reg <= p1_valid_reg;
                p3_valid_reg <= p2_valid_reg;
            end
            wsum_reg  <= wsum_next;
            wtsum_reg <= wtsum_next;
            count_reg <= count_next;
        end
    end

    // Payload stages, held on stall
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_item_reg   <= s_item;
            p2_diff_reg   <= p2_diff_next;
            p2_weight_reg <= p2_weight_next;
            p2_last_reg   <= p1_item_reg.last;
            p3_prod_reg   <= p3_prod_next;
            p3_weight_reg <= p2_weight_reg;
            p3_last_reg   <= p2_last_reg;
        end
    end

endmodule

`default_nettype wire

### rtl/mwmad_back.sv
// Back part: divides each snapshot's weighted sum by its weight sum, one bit a cycle.
// Saturates the quotient and drives the result register; depends on mwmad_pkg.
`default_nettype none

module mwmad_back (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     pop_valid,
    output logic                    pop_ready,
    input  mwmad_pkg::snap_t        pop_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output mwmad_pkg::out_item_t    m_item
);
    import mwmad_pkg::*;

    localparam int STEP_W = $clog2(WSUM_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [WSUM_W-1:0]      dvd_reg, dvd_next;
    logic [WTSUM_W-1:0]     rem_reg, rem_next;
    logic [WTSUM_W-1:0]     dvs_reg, dvs_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_item_reg, out_item_next;

    logic                   slot_free;
    logic                   no_data;
    logic                   do_pop;
    logic [WTSUM_W:0]       rem_shift;
    logic [WTSUM_W:0]       rem_sub;
    logic                   q_bit;

    assign slot_free = !out_valid_reg || m_ready;
    assign no_data   = (pop_data.weight_sum == '0);
    assign pop_ready = (state_reg == ST_IDLE) && (!no_data || slot_free);
    assign do_pop    = pop_valid && pop_ready;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    // One restoring division step
    always_comb begin
        rem_shift = {rem_reg, dvd_reg[WSUM_W-1]};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        q_bit     = (rem_shift >= {1'b0, dvs_reg});
    end

    // Sequence pop, divide and hand-off
    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (do_pop) begin
                    if (no_data) begin
                        out_item_next.distance = {{(DIST_W - COUNT_W - FRAC_W){1'b0}},
                                                  pop_data.element_count, {FRAC_W{1'b0}}};
                        out_item_next.no_data  = 1'b1;
                        out_valid_next         = 1'b1;
                    end else begin
                        dvd_next   = pop_data.weighted_sum;
                        dvs_next   = pop_data.weight_sum;
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rem_next  = q_bit ? rem_sub[WTSUM_W-1:0] : rem_shift[WTSUM_W-1:0];
                dvd_next  = {dvd_reg[WSUM_W-2:0], q_bit};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(WSUM_W - 1)) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (slot_free) begin
                    out_item_next.distance = (|dvd_reg[WSUM_W-1:DIST_W]) ? '1
                                                                         : dvd_reg[DIST_W-1:0];
                    out_item_next.no_data  = 1'b0;
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Divider datapath and result payload
    always_ff @(posedge aclk) begin
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire

### rtl/masked_weighted_mean_abs_distance.sv
// Top level of the masked weighted mean absolute distance block.
// Instantiates mwmad_front, mwmad_queue and mwmad_back; uses mwmad_pkg and the defines header.
//
// Usage:
//   s_valid/s_ready/s_item carry one score pair and weight per request; s_item.last
//   closes a vector. m_valid/m_ready/m_item return one result per vector.
//   cfg_we/cfg_wdata write the missing-value floor; write it only while idle.
// Throughput: one request per cycle while s_ready is high. Each vector with data
//   passes through the divider as a pop, 64 one-bit restoring steps and a hand-off;
//   a vector without data is handed off directly at the pop. Two finished vectors queue
//   between front and divider, so shorter vectors stall s_ready only once the queue fills.
// Path: the last request passes stages p1, p2 and p3 and the queue; with weight it then
//   goes through the divider to the result register, without weight straight to it.
// Reset: aresetn (synchronous, active low) clears accumulators, queue, divider state and
//   result valid flag, and sets the floor to -9999.0.
// Stall: while m_ready is low the result holds in its register; the divider and
//   queue fill, and the front then holds s_ready low until space frees.
`default_nettype none
`include "masked_weighted_mean_abs_distance_defines.svh"

module masked_weighted_mean_abs_distance #(
    parameter int QUEUE_DEPTH = mwmad_pkg::QUEUE_DEPTH
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    cfg_we,
    input  wire signed [mwmad_pkg::SCORE_W-1:0]    cfg_wdata,
    input  wire                                    s_valid,
    output logic                                   s_ready,
    input  mwmad_pkg::in_item_t                    s_item,
    output logic                                   m_valid,
    input  wire                                    m_ready,
    output mwmad_pkg::out_item_t                   m_item
);
    import mwmad_pkg::*;

    logic signed [SCORE_W-1:0]  floor_reg;
    logic                       q_push_valid, q_push_ready;
    snap_t                      q_push_data;
    logic                       q_pop_valid, q_pop_ready;
    snap_t                      q_pop_data;

    // Missing-value floor register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= FLOOR_RESET;
        end else if (cfg_we) begin
            floor_reg <= cfg_wdata;
        end
    end

    mwmad_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .missing_floor (floor_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .push_valid    (q_push_valid),
        .push_ready    (q_push_ready),
        .push_data     (q_push_data)
    );

    mwmad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    mwmad_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // A finished vector blocked by a full queue must stall the input
    `MWMAD_ASSERT_SAME(a_full_queue_stalls, aclk, aresetn,
        q_push_valid && !q_push_ready, !s_ready, "input accepted while snapshot is blocked")

    // A snapshot without weight turns into a no-data result in the next cycle
    `MWMAD_ASSERT_NEXT(a_no_data_result, aclk, aresetn,
        q_pop_valid && q_pop_ready && (q_pop_data.weight_sum == '0),
        m_valid && m_item.no_data, "no-data snapshot did not reach the result register")

    // A no-data result carries a whole element count
    `MWMAD_ASSERT_SAME(a_no_data_count, aclk, aresetn,
        m_valid && m_item.no_data, m_item.distance[FRAC_W-1:0] == '0,
        "no-data result has a fractional part")

endmodule

`default_nettype wire
